### rtl/assert_macros.svh
// Assertion macros for the gesture capture RTL.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, idle during reset.
`define GGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked implication checked in the cycle after the condition, idle during reset.
`define GGC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/ggc_pkg.sv
// Package for the gyro gesture code capture block: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int THRESH_W = 15;
    localparam int WIN_W    = 16;
    localparam int CODE_W   = 3;
    localparam int DIGIT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    // average magnitude never exceeds 2^15
    localparam int MAG_W    = SAMPLE_W + 1;

    localparam int DEF_MAX_WINDOW_SAMPLES = 1024;
    localparam int DEF_CODE_LENGTH        = 4;

    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(1000);
    localparam logic [WIN_W-1:0]    WINDOW_RST = WIN_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'b1;

    localparam logic signed [CODE_W-1:0] CODE_X_POS = 3'sd1;
    localparam logic signed [CODE_W-1:0] CODE_X_NEG = -3'sd1;
    localparam logic signed [CODE_W-1:0] CODE_Y_POS = 3'sd2;
    localparam logic signed [CODE_W-1:0] CODE_Y_NEG = -3'sd2;
    localparam logic signed [CODE_W-1:0] CODE_Z_POS = 3'sd3;
    localparam logic signed [CODE_W-1:0] CODE_Z_NEG = -3'sd3;

    typedef struct packed {
        logic clear;     // open a new window
        logic acc_en;    // add the current sample
        logic div_start; // close window, start averaging
    } lane_ctrl_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag; // |average|
        logic             pos; // average strictly positive
    } lane_res_t;

endpackage

`default_nettype wire

### rtl/ggc_axis_lane.sv
// One axis lane: threshold check, window sum and a bit-serial divider.
// Depends on ggc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ggc_axis_lane
    import ggc_pkg::*;
#(
    parameter int SUM_W = 27,
    parameter int CNT_W = 11
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic [THRESH_W-1:0]        threshold,
    output logic                            over_thresh,
    output lane_res_t                       res,
    output logic                            done
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]        quot_reg, quot_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        divisor_reg, divisor_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;

    logic signed [SAMPLE_W:0] sample_ext;
    logic [SAMPLE_W:0]        sample_abs;
    logic [CNT_W:0]           rem_sh;
    logic                     q_bit;

    assign sample_ext  = (SAMPLE_W + 1)'(sample);
    assign sample_abs  = sample_ext[SAMPLE_W] ? unsigned'(-sample_ext) : unsigned'(sample_ext);
    assign over_thresh = sample_abs > {2'b00, threshold};

    assign rem_sh = {rem_reg, quot_reg[SUM_W-1]};
    assign q_bit  = rem_sh >= {1'b0, divisor_reg};

    always_comb begin
        sum_next     = sum_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        done_next    = done_reg;
        neg_next     = neg_reg;
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.acc_en) begin
            sum_next = sum_reg + SUM_W'(sample);
        end
        if (ctrl.div_start) begin
            neg_next     = sum_reg[SUM_W-1];
            quot_next    = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
            rem_next     = '0;
            divisor_next = count;
            step_next    = STEP_W'(SUM_W);
            busy_next    = 1'b1;
            done_next    = 1'b0;
        end else if (busy_reg) begin
            // restoring division, one quotient bit per cycle
            rem_next  = q_bit ? CNT_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[CNT_W-1:0];
            quot_next = {quot_reg[SUM_W-2:0], q_bit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sum_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sum_reg  <= sum_next;
        end
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
    end

    assign res.mag = quot_reg[MAG_W-1:0];
    assign res.pos = !neg_reg && (quot_reg != '0);
    assign done    = done_reg;

endmodule

`default_nettype wire

### rtl/ggc_merge.sv
// Merge stage: picks the dominant axis from the three lane averages.
// Depends on ggc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ggc_merge
    import ggc_pkg::*;
(
    input  wire lane_res_t               res_x,
    input  wire lane_res_t               res_y,
    input  wire lane_res_t               res_z,
    output logic signed [CODE_W-1:0]     code
);

    always_comb begin
        // ties fall through to z; a zero average takes the negative code
        if (res_x.mag > res_y.mag && res_x.mag > res_z.mag) begin
            code = res_x.pos ? CODE_X_POS : CODE_X_NEG;
        end else if (res_y.mag > res_x.mag && res_y.mag > res_z.mag) begin
            code = res_y.pos ? CODE_Y_POS : CODE_Y_NEG;
        end else begin
            code = res_z.pos ? CODE_Z_POS : CODE_Z_NEG;
        end
    end

endmodule

`default_nettype wire

### rtl/gyro_gesture_code_capture_core.sv
// Flow: a sample that does not close a window is taken without holding off input.
// A closing sample starts three lane dividers that run SUM_W steps (one
// quotient bit a cycle); the result is then registered, and input is held
// off until it is, longer while the previous code still waits on m_ready.
// Reset (aresetn, synchronous, active low) returns to idle with registers at
// their defaults (threshold 1000, window 1000 ms) and digit position 0.
// Top level of the gesture capture block; depends on ggc_pkg, ggc_axis_lane,
// ggc_merge and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gyro_gesture_code_capture_core
    import ggc_pkg::*;
#(
    parameter int MAX_WINDOW_SAMPLES = DEF_MAX_WINDOW_SAMPLES,
    parameter int CODE_LENGTH        = DEF_CODE_LENGTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_rate_x,
    input  wire logic signed [SAMPLE_W-1:0] s_rate_y,
    input  wire logic signed [SAMPLE_W-1:0] s_rate_z,
    input  wire logic [TIME_W-1:0]          s_time_ms,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [CODE_W-1:0]        m_gesture_code,
    output logic [DIGIT_W-1:0]              m_digit_index,
    output logic                            m_code_done
);

    localparam int CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int DIG_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    typedef enum logic {ST_RUN, ST_DIV} state_t;

    state_t                  state_reg, state_next;
    logic [THRESH_W-1:0]     thresh_reg, thresh_next;
    logic [WIN_W-1:0]        window_reg, window_next;
    logic                    capturing_reg, capturing_next;
    logic [TIME_W-1:0]       start_reg, start_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [DIG_W-1:0]        digit_reg, digit_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [CODE_W-1:0] code_reg, code_next;
    logic [DIGIT_W-1:0]      index_reg, index_next;
    logic                    last_reg, last_next;

    lane_ctrl_t              ctrl;
    lane_res_t               res_x, res_y, res_z;
    logic                    over_x, over_y, over_z;
    logic                    done_x, done_y, done_z;
    logic signed [CODE_W-1:0] merged_code;

    logic                    accept;
    logic                    trigger;
    logic                    close_win;
    logic [TIME_W-1:0]       elapsed;
    logic                    last_digit;

    assign s_ready = (state_reg == ST_RUN);
    assign accept  = s_valid && s_ready;
    assign trigger = over_x || over_y || over_z;
    assign elapsed = s_time_ms - start_reg;
    assign close_win = (count_reg != '0) &&
                       (elapsed >= TIME_W'(window_reg) ||
                        count_reg >= CNT_W'(MAX_WINDOW_SAMPLES));

    assign ctrl.clear     = accept && !capturing_reg && trigger;
    assign ctrl.acc_en    = accept && capturing_reg && !close_win;
    assign ctrl.div_start = accept && capturing_reg && close_win;

    assign last_digit = ((DIG_W + 1)'(digit_reg) + (DIG_W + 1)'(1)) >=
                        (DIG_W + 1)'(CODE_LENGTH);

    ggc_axis_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_x (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .sample(s_rate_x),
        .count(count_reg), .threshold(thresh_reg), .over_thresh(over_x),
        .res(res_x), .done(done_x)
    );

    ggc_axis_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_y (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .sample(s_rate_y),
        .count(count_reg), .threshold(thresh_reg), .over_thresh(over_y),
        .res(res_y), .done(done_y)
    );

    ggc_axis_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_z (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .sample(s_rate_z),
        .count(count_reg), .threshold(thresh_reg), .over_thresh(over_z),
        .res(res_z), .done(done_z)
    );

    ggc_merge u_merge (
        .res_x(res_x), .res_y(res_y), .res_z(res_z), .code(merged_code)
    );

    always_comb begin
        state_next     = state_reg;
        thresh_next    = thresh_reg;
        window_next    = window_reg;
        capturing_next = capturing_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        digit_next     = digit_reg;
        m_valid_next   = m_valid_reg;
        code_next      = code_reg;
        index_next     = index_reg;
        last_next      = last_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_TRIGGER: thresh_next = cfg_wdata[THRESH_W-1:0];
                REG_WINDOW:  window_next = cfg_wdata[WIN_W-1:0];
                default:     ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN: begin
                if (ctrl.clear) begin
                    capturing_next = 1'b1;
                    start_next     = s_time_ms;
                    count_next     = '0;
                end else if (ctrl.acc_en) begin
                    count_next = count_reg + CNT_W'(1);
                end else if (ctrl.div_start) begin
                    capturing_next = 1'b0;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                // wait for the lanes and a free output register
                if (done_x && done_y && done_z && (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    code_next    = merged_code;
                    index_next   = DIGIT_W'(digit_reg);
                    last_next    = last_digit;
                    digit_next   = last_digit ? '0 : digit_reg + DIG_W'(1);
                    count_next   = '0;
                    state_next   = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            thresh_reg    <= THRESH_RST;
            window_reg    <= WINDOW_RST;
            capturing_reg <= 1'b0;
            start_reg     <= '0;
            count_reg     <= '0;
            digit_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            thresh_reg    <= thresh_next;
            window_reg    <= window_next;
            capturing_reg <= capturing_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            digit_reg     <= digit_next;
            m_valid_reg   <= m_valid_next;
        end
        code_reg  <= code_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_gesture_code = code_reg;
    assign m_digit_index  = index_reg;
    assign m_code_done    = last_reg;

    `GGC_ASSERT(a_lanes_in_step, (done_x == done_y) && (done_y == done_z), "lanes out of step")
    `GGC_ASSERT(a_code_nonzero, m_valid |-> (m_gesture_code != '0), "zero gesture code")
    `GGC_ASSERT(a_done_last_digit, (m_valid && m_code_done) |-> (m_digit_index == DIGIT_W'(CODE_LENGTH - 1)), "sequence end at wrong digit")
    `GGC_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_WINDOW_SAMPLES), "window count overflow")
    `GGC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_gesture_code), "item dropped")

endmodule

`default_nettype wire

### tb/sv/gyro_gesture_code_capture_core_tb.sv
// Testbench for gyro_gesture_code_capture_core: random valid/ready traffic,
// a cycle-free predictor of the gesture codes and an in-order result check.
// Depends on ggc_pkg and the core RTL only.
`timescale 1ns / 1ps

module gyro_gesture_code_capture_core_tb;
    import ggc_pkg::*;

    localparam int WINDOW_CAP = DEF_MAX_WINDOW_SAMPLES;
    localparam int SEQ_LEN    = DEF_CODE_LENGTH;
    localparam int SETTLE     = 40;

    typedef logic signed [SAMPLE_W-1:0] rate_t;

    typedef struct packed {
        rate_t             x;
        rate_t             y;
        rate_t             z;
        logic [TIME_W-1:0] t;
    } gyro_sample_t;

    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic [DIGIT_W-1:0]       digit;
        logic                     done;
    } gesture_code_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TRIGGER;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    rate_t s_rate_x = '0;
    rate_t s_rate_y = '0;
    rate_t s_rate_z = '0;
    logic [TIME_W-1:0] s_time_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CODE_W-1:0] m_gesture_code;
    logic [DIGIT_W-1:0] m_digit_index;
    logic m_code_done;

    gyro_gesture_code_capture_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rate_x       (s_rate_x),
        .s_rate_y       (s_rate_y),
        .s_rate_z       (s_rate_z),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gesture_code (m_gesture_code),
        .m_digit_index  (m_digit_index),
        .m_code_done    (m_code_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [THRESH_W-1:0] thr_q = THRESH_RST;
    logic [WIN_W-1:0]    win_q = WINDOW_RST;
    logic                win_open = 1'b0;
    logic [TIME_W-1:0]   win_start = '0;
    longint              acc_x = 0;
    longint              acc_y = 0;
    longint              acc_z = 0;
    int                  acc_cnt = 0;
    int                  digit_cnt = 0;

    gyro_sample_t  samples_todo[$];
    gesture_code_t codes_due[$];
    int            queued = 0;
    int            accepted = 0;
    int            mismatches = 0;
    logic          calm = 1'b0;
    logic [TIME_W-1:0] now = '0;

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_TRIGGER)
            thr_q = val[THRESH_W-1:0];
        else if (idx == REG_WINDOW)
            win_q = val[WIN_W-1:0];
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [CODE_W-1:0] dominant_axis(int ax, int ay, int az);
        int mx, my, mz;
        mx = magnitude(ax);
        my = magnitude(ay);
        mz = magnitude(az);
        if (mx > my && mx > mz)
            return (ax > 0) ? CODE_X_POS : CODE_X_NEG;
        if (my > mx && my > mz)
            return (ay > 0) ? CODE_Y_POS : CODE_Y_NEG;
        // ties and zero fall through to z
        return (az > 0) ? CODE_Z_POS : CODE_Z_NEG;
    endfunction

    function automatic void track_sample(gyro_sample_t s);
        logic [TIME_W-1:0] elapsed;
        gesture_code_t     res;
        int                th;
        th = int'(thr_q);
        if (!win_open) begin
            if (magnitude(int'(s.x)) > th || magnitude(int'(s.y)) > th ||
                magnitude(int'(s.z)) > th) begin
                win_open  = 1'b1;
                win_start = s.t;
                acc_x = 0;
                acc_y = 0;
                acc_z = 0;
                acc_cnt = 0;
            end
            return;
        end
        elapsed = s.t - win_start;
        if (acc_cnt != 0 && (elapsed >= {16'd0, win_q} || acc_cnt >= WINDOW_CAP)) begin
            res.code  = dominant_axis(int'(acc_x / acc_cnt), int'(acc_y / acc_cnt),
                                      int'(acc_z / acc_cnt));
            res.digit = digit_cnt[DIGIT_W-1:0];
            res.done  = (digit_cnt + 1 >= SEQ_LEN);
            codes_due.push_back(res);
            digit_cnt = res.done ? 0 : digit_cnt + 1;
            win_open = 1'b0;
            acc_cnt = 0;
            return;
        end
        acc_x += int'(s.x);
        acc_y += int'(s.y);
        acc_z += int'(s.z);
        acc_cnt++;
    endfunction

    // input driver
    gyro_sample_t send_item;
    int           send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (samples_todo.size() != 0) begin
                send_item = samples_todo.pop_front();
                s_rate_x  <= send_item.x;
                s_rate_y  <= send_item.y;
                s_rate_z  <= send_item.z;
                s_time_ms <= send_item.t;
                s_valid   <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 17);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    int stall_left = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor and checker
    gesture_code_t got;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_sample({s_rate_x, s_rate_y, s_rate_z, s_time_ms});
                accepted++;
            end
            if (m_valid && m_ready) begin
                if (codes_due.size() == 0) begin
                    $error("unexpected result: code %0d digit %0d done %0d",
                           m_gesture_code, m_digit_index, m_code_done);
                    mismatches++;
                end else begin
                    got = codes_due.pop_front();
                    if (m_gesture_code !== got.code) begin
                        $error("gesture_code: expected %0d, got %0d", got.code, m_gesture_code);
                        mismatches++;
                    end
                    if (m_digit_index !== got.digit) begin
                        $error("digit_index: expected %0d, got %0d", got.digit, m_digit_index);
                        mismatches++;
                    end
                    if (m_code_done !== got.done) begin
                        $error("code_done: expected %0d, got %0d", got.done, m_code_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    // stimulus helpers
    function automatic void add_sample(rate_t x, rate_t y, rate_t z, int unsigned dt);
        now += dt;
        samples_todo.push_back({x, y, z, now});
        queued++;
    endfunction

    function automatic rate_t signed_rate(int unsigned m);
        if (m >= 32768)
            return 16'sh8000;
        return $urandom_range(0, 1) ? -rate_t'(m) : rate_t'(m);
    endfunction

    function automatic rate_t quiet_rate();
        return signed_rate($urandom_range(0, thr_q));
    endfunction

    function automatic rate_t loud_rate();
        return signed_rate($urandom_range(int'(thr_q) + 1, 32768));
    endfunction

    function automatic void add_noise();
        now = $urandom;
        add_sample(rate_t'($urandom), rate_t'($urandom), rate_t'($urandom), 0);
    endfunction

    // idle lead-in, trigger, then samples until the window should close
    function automatic void add_gesture(int unsigned n_max);
        int unsigned       steps, span, b, cnt, i;
        int                d;
        logic              neg;
        logic [TIME_W-1:0] t0;
        rate_t             v[3];
        repeat ($urandom_range(0, 2))
            add_sample(quiet_rate(), quiet_rate(), quiet_rate(), $urandom_range(0, 50));
        v[0] = quiet_rate();
        v[1] = quiet_rate();
        v[2] = quiet_rate();
        v[$urandom_range(0, 2)] = loud_rate();
        add_sample(v[0], v[1], v[2], $urandom_range(0, 50));
        t0 = now;
        steps = $urandom_range(1, n_max);
        span = 2 * int'(win_q) / steps + 1;
        d = $urandom_range(0, 2);
        b = $urandom_range(0, 32767);
        neg = $urandom_range(0, 1);
        cnt = 0;
        do begin
            for (i = 0; i < 3; i++)
                v[i] = signed_rate($urandom_range(0, b / 2));
            v[d] = neg ? -rate_t'($urandom_range(b / 2, b)) : rate_t'($urandom_range(b / 2, b));
            if ($urandom_range(0, 15) == 0) begin
                v[0] = v[d];
                v[1] = v[d];
                v[2] = v[d];
            end
            if ($urandom_range(0, 40) == 0)
                add_noise();
            else
                add_sample(v[0], v[1], v[2], $urandom_range(0, span));
            cnt++;
        end while (!(cnt >= 2 && (now - t0) >= win_q) && cnt < 1100);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
    endtask

    // wait for every item to be taken and every code to come back
    task automatic drain();
        int n;
        while (accepted != queued)
            @(posedge aclk);
        n = 0;
        while (codes_due.size() != 0 && n < 3000) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int p, phase_end;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: threshold 1000, window 1000 ms; start near the time wrap
        now = 32'hFFFF_FF00;
        add_sample(1000, -1000, 0, 0);          // at threshold, not above
        add_sample(-32768, 0, 0, 5);            // trigger, not summed
        add_sample(32767, -32768, 0, 10);       // first sample always summed
        add_sample(32767, 0, 0, 490);           // timestamp wraps past zero
        add_sample(0, 0, 0, 500);               // closes: +x
        add_sample(0, 1001, 0, 3);
        add_sample(7, -7, 7, 1);                // three-way tie goes to z
        add_sample(0, 0, 0, 1000);
        add_sample(0, 0, -1001, 2);
        add_sample(4, -4, 0, 1);
        add_sample(-4, 4, 0, 1);                // all averages zero: -z
        add_sample(1, 1, 1, 999);
        add_sample(-1001, 0, 0, 0);
        add_sample(100, -20000, 0, 300);
        add_sample(-3, -20001, 2, 300);
        add_sample(0, 0, 0, 400);               // -y, completes the sequence
        add_sample(0, 0, 1001, 1);
        add_sample(-1, 0, 0, 1);                // -1/2 truncates to zero
        add_sample(0, 0, 0, 1);
        add_sample(0, 0, 0, 1000);
        drain();

        // zero threshold (bit 15 of the write is dropped) and zero window
        write_reg(REG_TRIGGER, 16'h8000);
        write_reg(REG_WINDOW, 16'h0000);
        add_sample(0, 0, 0, 1);
        add_sample(0, 0, 1, 1);
        add_sample(5, 6, -7, 0);
        add_sample(0, 0, 0, 0);
        add_sample(1, 0, 0, 0);
        add_sample(0, -9, 0, 0);
        add_sample(0, 0, 0, 50);
        drain();

        // top threshold, longest window: fill the window to its sample limit
        write_reg(REG_TRIGGER, 16'hFFFF);
        write_reg(REG_WINDOW, 16'hFFFF);
        add_sample(32767, -32767, 32767, 7);
        add_sample(0, 0, -32768, 1);
        repeat (WINDOW_CAP) add_sample(-32768, 32767, 100, 0);
        add_sample(0, 0, 0, 0);
        drain();

        for (p = 0; p < 6; p++) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_TRIGGER, {1'($urandom_range(0, 1)), 15'd0});
                1: write_reg(REG_TRIGGER, {1'($urandom_range(0, 1)), 15'h7FFF});
                default: write_reg(REG_TRIGGER, 16'($urandom));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(REG_WINDOW, 16'd0);
                1: write_reg(REG_WINDOW, 16'd1);
                2: write_reg(REG_WINDOW, 16'hFFFF);
                default: write_reg(REG_WINDOW, 16'($urandom_range(1, 300)));
            endcase
            calm = (p == 5);
            phase_end = queued + 20;
            while (queued < phase_end) begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3)) add_noise();
                add_gesture(($urandom_range(0, 9) == 0) ? 60 : 8);
            end
            drain();
        end

        if (codes_due.size() != 0) begin
            $error("%0d gesture codes never arrived", codes_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ggc_pkg.sv
rtl/ggc_axis_lane.sv
rtl/ggc_merge.sv
rtl/gyro_gesture_code_capture_core.sv
tb/sv/gyro_gesture_code_capture_core_tb.sv
